// ===== sv/cwr_pkg.sv =====
// Package for camera_world_rotation: widths, CORDIC constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package cwr_pkg;
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int TRIG_STAGES_DEF    = 16;
    localparam int TABLE_LEN          = 24;
    localparam int OUT_W              = 16;
    localparam int ANG_W              = 16;
    localparam int NUM_CFG            = 4;
    // config register indexes
    localparam logic [1:0] REG_NEGATE_YAW  = 2'd0;
    localparam logic [1:0] REG_MOUNT_ROLL  = 2'd1;
    localparam logic [1:0] REG_MOUNT_PITCH = 2'd2;
    localparam logic [1:0] REG_MOUNT_YAW   = 2'd3;
    // Q30 trig values, 32-bit turn angles
    localparam logic signed [33:0] QONE     = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_K0 = 34'sd652032875;

    typedef logic signed [33:0] trig_t;
    typedef logic signed [33:0] turn_t;

    function automatic turn_t atan_turn(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
                15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
                21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_turn = turn_t'({2'b00, v});
        end
    endfunction

    // clamp to +-1.0 in Q30
    function automatic trig_t clamp_q30(input logic signed [35:0] v);
        begin
            if (v > 36'(QONE))       clamp_q30 = QONE;
            else if (v < -36'(QONE)) clamp_q30 = -QONE;
            else                     clamp_q30 = trig_t'(v);
        end
    endfunction

    // Q30 x Q30 rounded half up back to Q30
    function automatic logic signed [35:0] mulq(input trig_t a, input trig_t b);
        logic signed [67:0] p;
        begin
            p = 68'(a) * 68'(b) + 68'sd536870912;
            mulq = 36'(p >>> 30);
        end
    endfunction
endpackage

// ===== sv/cwr_sincos.sv =====
// Pipelined rotation-mode CORDIC: one stage per iteration, stall by enable.
// Depends on cwr_pkg.
`timescale 1ns / 1ps
module cwr_sincos #(
    parameter int TRIG_STAGES = cwr_pkg::TRIG_STAGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  cwr_pkg::turn_t angle,
    output cwr_pkg::trig_t sin_q,
    output cwr_pkg::trig_t cos_q
);
    import cwr_pkg::*;
    localparam int N = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;

    logic signed [35:0] x_reg [0:N];
    logic signed [35:0] y_reg [0:N];
    turn_t              z_reg [0:N];
    logic               f_reg [0:N];

    // range reduction into +-pi/2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= 36'(CORDIC_K0);
            y_reg[0] <= '0;
            if (angle > turn_t'(34'sd1073741824))
            begin
                z_reg[0] <= angle - turn_t'(34'sd2147483648);
                f_reg[0] <= 1'b1;
            end
            else if (angle < -turn_t'(34'sd1073741824))
            begin
                z_reg[0] <= angle + turn_t'(34'sd2147483648);
                f_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= angle;
                f_reg[0] <= 1'b0;
            end
        end
    end

    // micro-rotations
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[i+1] <= f_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turn(i);
                end
            end
        end
    end

    // unflip and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q <= clamp_q30(f_reg[N] ? -x_reg[N] : x_reg[N]);
            sin_q <= clamp_q30(f_reg[N] ? -y_reg[N] : y_reg[N]);
        end
    end

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

// ===== sv/camera_world_rotation.sv =====
// Camera-in-world rotation; the CORDIC pipelines set the depth.
// Throughput one transaction per cycle while the output is not stalled.
// A full output stall freezes the whole pipeline; nothing is lost.
// Reset (rst_n, async, active low) clears valid bits and config registers.
// Depends on cwr_pkg, cwr_sincos.
`timescale 1ns / 1ps
module camera_world_rotation #(
    parameter int ANGLE_BITS     = cwr_pkg::ANGLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = cwr_pkg::COEF_FRAC_BITS_DEF,
    parameter int TRIG_STAGES    = cwr_pkg::TRIG_STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // body_roll, body_pitch, body_yaw
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // m00, m01, m02, m10, ..., m22
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import cwr_pkg::*;
    localparam int N    = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;
    localparam int LAT  = N + 7;
    localparam int OSH  = 60 - COEF_FRAC_BITS;

    function automatic turn_t to_turn(input logic [ANG_W-1:0] raw);
        logic signed [ANGLE_BITS-1:0] a;
        begin
            a = ANGLE_BITS'(raw);
            to_turn = turn_t'(a) <<< (32 - ANGLE_BITS);
        end
    endfunction

    // config registers
    logic            neg_reg;
    logic [15:0]     mnt_reg [0:2];
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
            mnt_reg[0] <= '0; mnt_reg[1] <= '0; mnt_reg[2] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NEGATE_YAW:  neg_reg    <= cfg_data[0];
                REG_MOUNT_ROLL:  mnt_reg[0] <= cfg_data;
                REG_MOUNT_PITCH: mnt_reg[1] <= cfg_data;
                REG_MOUNT_YAW:   mnt_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable and valid chain
    logic           en;
    logic [LAT-1:0] v_reg;
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;
    assign m_tvalid = v_reg[LAT-1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      v_reg <= '0;
        else if (en)     v_reg <= {v_reg[LAT-2:0], s_tvalid};
    end

    // six angles: body r,p,y then mount r,p,y
    turn_t ang [0:5];
    trig_t sn [0:5];
    trig_t cs [0:5];
    turn_t yw;
    assign yw     = to_turn(s_tdata[47:32]);
    assign ang[0] = to_turn(s_tdata[15:0]);
    assign ang[1] = to_turn(s_tdata[31:16]);
    assign ang[2] = neg_reg ? -yw : yw;
    assign ang[3] = to_turn(mnt_reg[0]);
    assign ang[4] = to_turn(mnt_reg[1]);
    assign ang[5] = to_turn(mnt_reg[2]);
    for (genvar g = 0; g < 6; g++)
    begin : g_trig
        cwr_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sc (
            .clk(clk), .rst_n(rst_n), .en(en), .angle(ang[g]),
            .sin_q(sn[g]), .cos_q(cs[g]));
    end

    // euler stage A: cy*sp, sy*sp and single products
    trig_t cysp_reg [0:1], sysp_reg [0:1], sr_reg [0:1], cr_reg [0:1];
    trig_t sy_reg [0:1], cy_reg [0:1];
    logic signed [35:0] e00_reg [0:1], e10_reg [0:1], e21_reg [0:1], e22_reg [0:1];
    trig_t e20_reg [0:1];
    for (genvar e = 0; e < 2; e++)
    begin : g_ea
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cysp_reg[e] <= trig_t'(mulq(cs[3*e+2], sn[3*e+1]));
                sysp_reg[e] <= trig_t'(mulq(sn[3*e+2], sn[3*e+1]));
                e00_reg[e]  <= mulq(cs[3*e+2], cs[3*e+1]);
                e10_reg[e]  <= mulq(sn[3*e+2], cs[3*e+1]);
                e21_reg[e]  <= mulq(cs[3*e+1], sn[3*e]);
                e22_reg[e]  <= mulq(cs[3*e+1], cs[3*e]);
                e20_reg[e]  <= -sn[3*e+1];
                sr_reg[e] <= sn[3*e]; cr_reg[e] <= cs[3*e];
                sy_reg[e] <= sn[3*e+2]; cy_reg[e] <= cs[3*e+2];
            end
        end
    end

    // euler stage B: finish and clamp
    trig_t mb_reg [0:8];
    trig_t mm_reg [0:8];
    for (genvar e = 0; e < 2; e++)
    begin : g_eb
        trig_t r [0:8];
        always_comb
        begin
            r[0] = clamp_q30(e00_reg[e]);
            r[1] = clamp_q30(mulq(cysp_reg[e], sr_reg[e]) - mulq(sy_reg[e], cr_reg[e]));
            r[2] = clamp_q30(mulq(cysp_reg[e], cr_reg[e]) + mulq(sy_reg[e], sr_reg[e]));
            r[3] = clamp_q30(e10_reg[e]);
            r[4] = clamp_q30(mulq(sysp_reg[e], sr_reg[e]) + mulq(cy_reg[e], cr_reg[e]));
            r[5] = clamp_q30(mulq(sysp_reg[e], cr_reg[e]) - mulq(cy_reg[e], sr_reg[e]));
            r[6] = clamp_q30(36'(e20_reg[e]));
            r[7] = clamp_q30(e21_reg[e]);
            r[8] = clamp_q30(e22_reg[e]);
        end
        for (genvar k = 0; k < 9; k++)
        begin : g_k
            if (e == 0)
            begin : g_body
                always_ff @(posedge clk)
                begin
                    if (en) mb_reg[k] <= r[k];
                end
            end
            else
            begin : g_mount
                always_ff @(posedge clk)
                begin
                    if (en) mm_reg[k] <= r[k];
                end
            end
        end
    end

    // permuted mount matrix rows: m1, -m2, m0
    trig_t pm [0:8];
    for (genvar j = 0; j < 3; j++)
    begin : g_pm
        assign pm[j]   = mm_reg[3+j];
        assign pm[3+j] = -mm_reg[6+j];
        assign pm[6+j] = mm_reg[j];
    end

    // product stage: 27 products registered
    logic signed [67:0] pr_reg [0:26];
    for (genvar i = 0; i < 3; i++)
    begin : g_pi
        for (genvar j = 0; j < 3; j++)
        begin : g_pj
            for (genvar k = 0; k < 3; k++)
            begin : g_pk
                always_ff @(posedge clk)
                begin
                    if (en) pr_reg[9*i+3*j+k] <= 68'(pm[3*i+k]) * 68'(mb_reg[3*k+j]);
                end
            end
        end
    end

    // sum stage
    logic signed [69:0] acc_reg [0:8];
    for (genvar q = 0; q < 9; q++)
    begin : g_sum
        always_ff @(posedge clk)
        begin
            if (en) acc_reg[q] <= 70'(pr_reg[3*q]) + 70'(pr_reg[3*q+1]) + 70'(pr_reg[3*q+2]);
        end
    end

    // round, clamp, pack
    for (genvar q = 0; q < 9; q++)
    begin : g_out
        logic signed [69:0] rv;
        logic signed [69:0] lim;
        assign rv  = (acc_reg[q] + (70'sd1 <<< (OSH - 1))) >>> OSH;
        assign lim = 70'sd1 <<< COEF_FRAC_BITS;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rv > lim)       m_tdata[16*q +: 16] <= lim[15:0];
                else if (rv < -lim) m_tdata[16*q +: 16] <= 16'(-lim);
                else                m_tdata[16*q +: 16] <= rv[15:0];
            end
        end
    end

`ifndef SYNTH
    // a stalled output never drops its transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    // input taken means a valid enters the chain
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted transaction lost");
`endif
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for camera_world_rotation.
// Predicts each rotation matrix with an in-bench fixed-point CORDIC model and
// compares it entry by entry. Depends on cwr_pkg and the camera_world_rotation RTL.
`timescale 1ns / 1ps
module testbench;
    import cwr_pkg::*;

    localparam int LATENCY = 24;

    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
    } attitude_t;

    typedef logic signed [63:0] q_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    camera_world_rotation DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the configuration registers
    logic        sh_negate;
    logic [15:0] sh_mount [3];

    attitude_t    pending_q [$];
    logic [143:0] matrix_q [$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         send_hold;
    logic         in_busy;

    // ---------------- predictor ----------------
    function automatic q_t fshift(q_t v, int s);
        return v >>> s;
    endfunction

    function automatic q_t clip(q_t v, q_t lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic q_t turn_of(logic [15:0] a);
        q_t v;
        v = q_t'($signed(a));
        return v * 65536;
    endfunction

    function automatic q_t qmul(q_t a, q_t b);
        return fshift(a * b + (q_t'(1) <<< 29), 30);
    endfunction

    function automatic void sincos(input q_t a, output q_t s, output q_t c);
        q_t x, y, z, dx, dy;
        logic flip;
        flip = 1'b0;
        x = 64'sd652032875;
        y = 0;
        if (a > (q_t'(1) <<< 30)) begin a = a - (q_t'(1) <<< 31); flip = 1'b1; end
        else if (a < -(q_t'(1) <<< 30)) begin a = a + (q_t'(1) <<< 31); flip = 1'b1; end
        z = a;
        for (int i = 0; i < TRIG_STAGES_DEF; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - q_t'(atan_turn(i));
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + q_t'(atan_turn(i));
            end
        end
        if (flip) begin x = -x; y = -y; end
        c = clip(x, q_t'(1) <<< 30);
        s = clip(y, q_t'(1) <<< 30);
    endfunction

    function automatic void zyx_matrix(input q_t r, input q_t p, input q_t yw,
                                       output q_t m [3][3]);
        q_t sr, cr, sp, cp, sy, cy, cysp, sysp;
        sincos(r, sr, cr);
        sincos(p, sp, cp);
        sincos(yw, sy, cy);
        cysp = qmul(cy, sp);
        sysp = qmul(sy, sp);
        m[0][0] = qmul(cy, cp);
        m[0][1] = qmul(cysp, sr) - qmul(sy, cr);
        m[0][2] = qmul(cysp, cr) + qmul(sy, sr);
        m[1][0] = qmul(sy, cp);
        m[1][1] = qmul(sysp, sr) + qmul(cy, cr);
        m[1][2] = qmul(sysp, cr) - qmul(cy, sr);
        m[2][0] = -sp;
        m[2][1] = qmul(cp, sr);
        m[2][2] = qmul(cp, cr);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = clip(m[i][j], q_t'(1) <<< 30);
    endfunction

    function automatic logic [143:0] camera_matrix(attitude_t a);
        q_t b [3][3];
        q_t mt [3][3];
        q_t pm [3][3];
        q_t yw, acc, v;
        logic [143:0] res;
        yw = turn_of(a.yaw);
        if (sh_negate) yw = -yw;
        zyx_matrix(turn_of(a.roll), turn_of(a.pitch), yw, b);
        zyx_matrix(turn_of(sh_mount[0]), turn_of(sh_mount[1]), turn_of(sh_mount[2]), mt);
        // body-to-camera axis permutation
        for (int j = 0; j < 3; j++)
        begin
            pm[0][j] = mt[1][j];
            pm[1][j] = -mt[2][j];
            pm[2][j] = mt[0][j];
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = acc + pm[i][k] * b[k][j];
                v = fshift(acc + (q_t'(1) <<< (59 - COEF_FRAC_BITS_DEF)),
                           60 - COEF_FRAC_BITS_DEF);
                v = clip(v, q_t'(1) <<< COEF_FRAC_BITS_DEF);
                res[(i * 3 + j) * 16 +: 16] = v[15:0];
            end
        return res;
    endfunction

    // ---------------- clock and limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("camera_world_rotation regression: fail");
        $finish;
    end

    // ---------------- input driver ----------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_busy)
            begin
                if (pending_q.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predict on each accepted input transaction; note a held one
    always @(posedge clk)
    begin
        in_busy <= rst_n && s_tvalid && !s_tready;
        if (rst_n && s_tvalid && s_tready)
            matrix_q.push_back(camera_matrix(attitude_t'(s_tdata)));
    end

    // ---------------- output monitor ----------------
    always @(posedge clk)
    begin
        logic [143:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (matrix_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", m_tdata);
            end
            else
            begin
                want = matrix_q.pop_front();
                for (int e = 0; e < 9; e++)
                    if (want[e * 16 +: 16] !== m_tdata[e * 16 +: 16])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("entry m%0d%0d: expected %0d got %0d", e / 3, e % 3,
                                     $signed(want[e * 16 +: 16]),
                                     $signed(m_tdata[e * 16 +: 16]));
                    end
            end
        end
    end

    // ---------------- sequencing ----------------
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_NEGATE_YAW) sh_negate = val[0];
        else sh_mount[idx - 1] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || matrix_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h4000 + 16'($urandom_range(4) - 2);
            3: return 16'hC000 + 16'($urandom_range(4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n);
        attitude_t a;
        for (int i = 0; i < n; i++)
        begin
            a.roll = rand_angle();
            a.pitch = rand_angle();
            a.yaw = rand_angle();
            pending_q.push_back(a);
        end
    endtask

    initial
    begin
        logic [15:0] edges [8];
        attitude_t a;
        edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000,
                  16'h4001, 16'hBFFF, 16'hFFFF};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_NEGATE_YAW;
        cfg_data = '0;
        sh_negate = 1'b0;
        sh_mount = '{16'h0, 16'h0, 16'h0};
        mismatches = 0;
        send_idle_pct = 33;
        recv_idle_pct = 75;
        send_hold = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: angle extremes, quarter turns, wrap at pi
        for (int i = 0; i < 8; i++)
        begin
            a.roll = edges[i];
            a.pitch = edges[(i + 3) % 8];
            a.yaw = edges[(i + 5) % 8];
            pending_q.push_back(a);
        end
        for (int i = 0; i < 8; i++)
        begin
            a.roll = edges[i]; a.pitch = edges[i]; a.yaw = edges[i];
            pending_q.push_back(a);
        end
        drain();

        // negated yaw with pi yaw, mount at extremes
        write_reg(REG_NEGATE_YAW, 16'h0001);
        write_reg(REG_MOUNT_ROLL, 16'h8000);
        write_reg(REG_MOUNT_PITCH, 16'h7FFF);
        write_reg(REG_MOUNT_YAW, 16'h4000);
        a.roll = 16'h0; a.pitch = 16'h0; a.yaw = 16'h8000;
        pending_q.push_back(a);
        add_random(400);
        drain();

        // swap idling pattern; pause sender until everything has drained
        send_idle_pct = 75;
        recv_idle_pct = 33;
        write_reg(REG_NEGATE_YAW, 16'h0000);
        write_reg(REG_MOUNT_ROLL, 16'(($urandom)));
        write_reg(REG_MOUNT_PITCH, 16'hC000);
        write_reg(REG_MOUNT_YAW, 16'h8000);
        add_random(300);
        repeat (200) @(posedge clk);
        send_hold = 1'b1;
        repeat (40) @(posedge clk);
        while (matrix_q.size() > 0 || s_tvalid) @(posedge clk);
        send_hold = 1'b0;
        add_random(300);
        drain();

        // no idling, random mount angles, then mount angles at extremes
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_NEGATE_YAW, 16'($urandom));
            write_reg(REG_MOUNT_ROLL, 16'($urandom));
            write_reg(REG_MOUNT_PITCH, 16'($urandom));
            write_reg(REG_MOUNT_YAW, 16'($urandom));
            add_random(200);
            drain();
        end
        write_reg(REG_MOUNT_ROLL, 16'h7FFF);
        write_reg(REG_MOUNT_PITCH, 16'h8000);
        write_reg(REG_MOUNT_YAW, 16'h7FFF);
        add_random(30);
        drain();

        if (mismatches == 0 && matrix_q.size() == 0)
            $display("camera_world_rotation regression: pass");
        else
            $display("camera_world_rotation regression: fail");
        $finish;
    end
endmodule

// ===== camera_world_rotation.f =====
sv/cwr_pkg.sv
sv/cwr_sincos.sv
sv/camera_world_rotation.sv
tb/testbench.sv
